[hdl/alr_pkg.sv]
package alr_pkg;

  // Default geometry and fixed-point format.
  localparam int COORD_BITS_DEF = 11;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed widths of the colour and coverage fields.
  localparam int COLOR_BITS = 8;
  localparam int COV_BITS   = 8;

  // Command codes carried in the mode field.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Status of the slope divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/alr_cmd_if.sv]
interface alr_cmd_if #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF
);
  import alr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  logic [COLOR_BITS-1:0] red_in;
  logic [COLOR_BITS-1:0] green_in;
  logic [COLOR_BITS-1:0] blue_in;

  modport source (
    output valid, mode, x_start, y_start, x_end, y_end, red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, mode, x_start, y_start, x_end, y_end, red_in, green_in, blue_in,
    output ready
  );

endinterface

[hdl/alr_pix_if.sv]
interface alr_pix_if #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF
);
  import alr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [COV_BITS-1:0]   coverage;
  logic [COLOR_BITS-1:0] red_out;
  logic [COLOR_BITS-1:0] green_out;
  logic [COLOR_BITS-1:0] blue_out;
  logic                  last_of_step;
  logic                  segment_done;

  modport source (
    output valid, pixel_x, pixel_y, coverage, red_out, green_out, blue_out,
           last_of_step, segment_done,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, coverage, red_out, green_out, blue_out,
           last_of_step, segment_done,
    output ready
  );

endinterface

[hdl/alr_div.sv]
module alr_div #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COORD_BITS:0]   minor,
  input  logic [COORD_BITS:0]   major,
  output alr_pkg::div_stat_t    stat,
  output logic [FRAC_BITS:0]    quotient
);
  import alr_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(FRAC_BITS);

  logic [COORD_BITS+1:0] rem;
  logic [COORD_BITS:0]   divisor;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;
  logic                  ge;
  logic [COORD_BITS+1:0] rem_sub;

  // One restoring step: compare, conditionally subtract, then shift.
  // The minor delta never exceeds the major one, so the partial remainder
  // starts at the minor delta and one quotient bit falls out per cycle.
  assign ge      = rem >= {1'b0, divisor};
  assign rem_sub = ge ? (rem - {1'b0, divisor}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem     <= {1'b0, minor};
        divisor <= major;
        cnt     <= CNT_INIT;
        busy    <= 1'b1;
      end else if (busy) begin
        quotient <= {quotient[FRAC_BITS-1:0], ge};
        rem      <= {rem_sub[COORD_BITS:0], 1'b0};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[hdl/alr_cov.sv]
module alr_cov #(
  parameter int FRAC_BITS = alr_pkg::FRAC_BITS_DEF
) (
  input  logic [FRAC_BITS:0]          frac,
  output logic [alr_pkg::COV_BITS-1:0] coverage
);
  import alr_pkg::*;

  logic [FRAC_BITS+COV_BITS:0] scaled;

  // Multiply by 255 as a shift and a subtract, then drop the fraction.
  // The fraction never exceeds 1.0, so the result stays within 0 to 255.
  assign scaled   = {frac, {COV_BITS{1'b0}}} - {{COV_BITS{1'b0}}, frac};
  assign coverage = scaled[FRAC_BITS+COV_BITS-1:FRAC_BITS];

endmodule

[hdl/antialiased_line_rasterizer_top.sv]
// Antialiased line rasterizer. A load item (mode 0) takes two endpoints and a
// colour, orders them so x rises and starts the slope division; it produces no
// pixel and occupies the block until the restoring divider, which yields one
// quotient bit per cycle, has finished. A step item (mode 1) advances one
// position along the major axis and emits one pixel, or two when the
// accumulator carries, each with its coverage; it occupies the block while it
// emits them, also while the pixel channel stalls. A step item with no
// segment loaded is accepted and dropped. The command channel is ready only
// while the sequencer is idle; an emitted pixel waits in the output register,
// so the next item can be taken meanwhile.
module antialiased_line_rasterizer_top #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
  input logic            clk,
  input logic            rst,
  alr_cmd_if.sink        cmd,
  alr_pix_if.source      pix
);
  import alr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_EMIT1,
    S_EMIT2
  } state_t;

  localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  state_t                state;
  logic                  active;
  logic                  steep;
  logic                  y_step_down;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [COORD_BITS:0]   steps_left;
  logic [FRAC_BITS-1:0]  accumulator;
  logic [FRAC_BITS:0]    slope;
  logic [COLOR_BITS-1:0] seg_red;
  logic [COLOR_BITS-1:0] seg_green;
  logic [COLOR_BITS-1:0] seg_blue;
  logic                  seg_last;

  // Output register.
  logic                  pix_valid;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [COV_BITS-1:0]   pix_cov;
  logic [COLOR_BITS-1:0] pix_red;
  logic [COLOR_BITS-1:0] pix_green;
  logic [COLOR_BITS-1:0] pix_blue;
  logic                  pix_last;
  logic                  pix_done;

  logic                  cmd_take;
  logic                  swap;
  logic [FRAC_BITS:0]    acc_sum;
  logic [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]   dy;
  logic                  ydown;
  logic                  is_steep;
  logic [COORD_BITS:0]   major;
  logic [COORD_BITS:0]   minor;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [FRAC_BITS:0]    div_q;
  logic [FRAC_BITS:0]    cov_arg;
  logic [COV_BITS-1:0]   cov_val;
  logic                  out_free;
  logic                  pix_load;
  logic [COORD_BITS-1:0] y_moved;
  logic [COORD_BITS-1:0] x_moved;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_take  = cmd.valid && cmd.ready;

  // Endpoint ordering on load, so that x rises from the stored start point.
  assign swap = cmd.x_end < cmd.x_start;

  // Accumulator update for a step; bit FRAC_BITS is the carry past 1.0.
  assign acc_sum = {1'b0, accumulator} + slope;

  // Deltas and axis choice, worked out from the ordered endpoints.
  assign dx       = {1'b0, end_x} - {1'b0, cur_x} + (COORD_BITS+1)'(1);
  assign ydown    = !(cur_y < end_y);
  assign dy       = (ydown ? ({1'b0, cur_y} - {1'b0, end_y})
                           : ({1'b0, end_y} - {1'b0, cur_y})) + (COORD_BITS+1)'(1);
  assign is_steep = dx < dy;
  assign major    = is_steep ? dy : dx;
  assign minor    = is_steep ? dx : dy;
  assign div_start = (state == S_PREP);

  alr_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .minor    (minor),
    .major    (major),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // The carry pixel is weighted by 1 - S, the regular pixel by S.
  assign cov_arg = (state == S_EMIT1) ? (ONE_FX - {1'b0, accumulator})
                                      : {1'b0, accumulator};

  alr_cov #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cov (
    .frac     (cov_arg),
    .coverage (cov_val)
  );

  assign out_free = !pix_valid || pix.ready;
  assign pix_load = ((state == S_EMIT1) || (state == S_EMIT2)) && out_free;
  assign y_moved  = y_step_down ? (cur_y - COORD_BITS'(1)) : (cur_y + COORD_BITS'(1));
  assign x_moved  = cur_x + COORD_BITS'(1);

  // Sequencer, segment state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (pix_load) begin
        pix_valid <= 1'b1;
      end else if (pix.ready) begin
        pix_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            if (cmd.mode == MODE_LOAD) begin
              cur_x       <= swap ? cmd.x_end : cmd.x_start;
              cur_y       <= swap ? cmd.y_end : cmd.y_start;
              end_x       <= swap ? cmd.x_start : cmd.x_end;
              end_y       <= swap ? cmd.y_start : cmd.y_end;
              seg_red     <= cmd.red_in;
              seg_green   <= cmd.green_in;
              seg_blue    <= cmd.blue_in;
              accumulator <= '0;
              active      <= 1'b1;
              state       <= S_PREP;
            end else if (active) begin
              accumulator <= acc_sum[FRAC_BITS-1:0];
              seg_last    <= steps_left <= (COORD_BITS+1)'(1);
              state       <= acc_sum[FRAC_BITS] ? S_EMIT1 : S_EMIT2;
            end
          end
        end
        S_PREP: begin
          y_step_down <= ydown;
          steep       <= is_steep;
          steps_left  <= major;
          state       <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            slope <= div_q;
            state <= S_IDLE;
          end
        end
        S_EMIT1: begin
          if (out_free) begin
            pix_x     <= cur_x;
            pix_y     <= cur_y;
            pix_cov   <= cov_val;
            pix_red   <= seg_red;
            pix_green <= seg_green;
            pix_blue  <= seg_blue;
            pix_last  <= 1'b0;
            pix_done  <= seg_last;
            if (steep) begin
              cur_x <= x_moved;
            end else begin
              cur_y <= y_moved;
            end
            state <= S_EMIT2;
          end
        end
        S_EMIT2: begin
          if (out_free) begin
            pix_x     <= cur_x;
            pix_y     <= cur_y;
            pix_cov   <= cov_val;
            pix_red   <= seg_red;
            pix_green <= seg_green;
            pix_blue  <= seg_blue;
            pix_last  <= 1'b1;
            pix_done  <= seg_last;
            if (steep) begin
              cur_y <= y_moved;
            end else begin
              cur_x <= x_moved;
            end
            if (seg_last) begin
              steps_left <= '0;
              active     <= 1'b0;
            end else begin
              steps_left <= steps_left - (COORD_BITS+1)'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign pix.valid        = pix_valid;
  assign pix.pixel_x      = pix_x;
  assign pix.pixel_y      = pix_y;
  assign pix.coverage     = pix_cov;
  assign pix.red_out      = pix_red;
  assign pix.green_out    = pix_green;
  assign pix.blue_out     = pix_blue;
  assign pix.last_of_step = pix_last;
  assign pix.segment_done = pix_done;

`ifndef SYNTHESIS
  // New commands are never taken while the divider is still working.
  assert property (@(posedge clk) disable iff (rst) cmd.ready |-> !div_stat.busy)
    else $error("command accepted while slope division in progress");

  // Pixels only come from a loaded segment.
  assert property (@(posedge clk) disable iff (rst) pix_load |-> active)
    else $error("pixel emitted with no active segment");

  // The final pixel of the final step retires the segment.
  assert property (@(posedge clk) disable iff (rst)
    (pix_load && seg_last && (state == S_EMIT2)) |=> !active)
    else $error("segment still active after its last step");

  // An idle, active segment always has at least one position left to draw.
  assert property (@(posedge clk) disable iff (rst)
    (active && (state == S_IDLE)) |-> (steps_left != '0))
    else $error("active segment with no steps left");
`endif

endmodule
